@@ sv/ipdt_pkg.sv @@
// ----------------------------------------------------------------------------
// ipdt_pkg: shared definitions for the interval phase delay tracker
// Holds the default widths, the register indexes, the queue depth, the lane
// map of the modulo unit and the status types passed between modules.
// ----------------------------------------------------------------------------
package ipdt_pkg;

  // Default field widths.
  localparam int SAMPLE_COUNT_WIDTH_DEF = 24;
  localparam int FRAME_COUNT_WIDTH_DEF  = 16;
  localparam int LATENCY_WIDTH          = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUTPUT_LATENCY = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INPUT_LATENCY  = 2'd1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Lanes of the shared modulo unit, all reduced by the same interval length.
  localparam int NUM_LANES = 5;
  localparam int LN_CURSOR = 0;
  localparam int LN_PHASE  = 1;
  localparam int LN_OUTLAT = 2;
  localparam int LN_INLAT  = 3;
  localparam int LN_FRAMES = 4;

  // Queue fill status.
  typedef struct packed {
    logic empty;
    logic full;
  } ipdt_qstat_t;

  // Modulo unit status.
  typedef struct packed {
    logic last_step;
  } ipdt_modstat_t;

endpackage

@@ sv/ipdt_queue.sv @@
// ----------------------------------------------------------------------------
// ipdt_queue: short word queue between the front and the back
// A small circular buffer of classified words; it lets the front keep taking
// words while the back is busy with an earlier one.
// ----------------------------------------------------------------------------
module ipdt_queue #(
  parameter int DATA_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_W-1:0]    data_i,
  input  logic                 pop_i,
  output logic [DATA_W-1:0]    data_o,
  output ipdt_pkg::ipdt_qstat_t stat_o
);
  import ipdt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  // Pushes into a full queue and pops from an empty one are ignored.
  assign do_push = push_i && (count_q != CNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign data_o       = entry_q[rd_ptr_q];

  // Pointer and count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/ipdt_front.sv @@
// ----------------------------------------------------------------------------
// ipdt_front: input side of the delay tracker
// Takes words from the input channel, marks those that carry no timing and
// packs them for the queue. It stalls the channel while the queue is full.
// ----------------------------------------------------------------------------
module ipdt_front #(
  parameter int SAMPLE_COUNT_WIDTH = ipdt_pkg::SAMPLE_COUNT_WIDTH_DEF,
  parameter int FRAME_COUNT_WIDTH  = ipdt_pkg::FRAME_COUNT_WIDTH_DEF
) (
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [SAMPLE_COUNT_WIDTH-1:0]         interval_length_i,
  input  logic [SAMPLE_COUNT_WIDTH-1:0]         interval_phase_i,
  input  logic [SAMPLE_COUNT_WIDTH-1:0]         write_cursor_i,
  input  logic [FRAME_COUNT_WIDTH-1:0]          block_frames_i,
  input  ipdt_pkg::ipdt_qstat_t                 qstat_i,
  output logic                                  push_o,
  output logic [3*SAMPLE_COUNT_WIDTH+FRAME_COUNT_WIDTH:0] item_o
);
  import ipdt_pkg::*;

  logic no_timing;

  // A zero interval length means the remote side has no timing yet.
  assign no_timing = (interval_length_i == '0);

  // The channel stalls only on a full queue.
  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  // Word layout, most significant first: no-timing flag, length, phase,
  // cursor, frames.
  assign item_o = {no_timing, interval_length_i, interval_phase_i, write_cursor_i,
                   block_frames_i};

endmodule

@@ sv/ipdt_mod_unit.sv @@
// ----------------------------------------------------------------------------
// ipdt_mod_unit: multi-lane iterative modulo unit
// Reduces several operands by one shared divisor with a restoring remainder
// step, one dividend bit per cycle in every lane.
// ----------------------------------------------------------------------------
module ipdt_mod_unit #(
  parameter int DIV_W = ipdt_pkg::SAMPLE_COUNT_WIDTH_DEF,
  parameter int OP_W  = ipdt_pkg::SAMPLE_COUNT_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  input  logic [DIV_W-1:0]                                div_i,
  input  logic [ipdt_pkg::NUM_LANES-1:0][OP_W-1:0]        op_i,
  output logic [ipdt_pkg::NUM_LANES-1:0][DIV_W-1:0]       rem_o,
  output ipdt_pkg::ipdt_modstat_t                         stat_o
);
  import ipdt_pkg::*;

  localparam int CNT_W = $clog2(OP_W + 1);

  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [DIV_W-1:0]                  div_q;
  logic [NUM_LANES-1:0][OP_W-1:0]    dvd_q, dvd_d;
  logic [NUM_LANES-1:0][DIV_W-1:0]   rem_q, rem_d;
  logic [NUM_LANES-1:0][DIV_W:0]     shifted;
  logic                              stepping;

  assign stepping         = (cnt_q != '0);
  assign stat_o.last_step = (cnt_q == CNT_W'(1));
  assign rem_o            = rem_q;

  // One restoring step per lane: shift in the next dividend bit and take
  // the divisor off when it fits.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      shifted[l] = {rem_q[l], dvd_q[l][OP_W-1]};
      if (shifted[l] >= {1'b0, div_q}) begin
        rem_d[l] = DIV_W'(shifted[l] - {1'b0, div_q});
      end else begin
        rem_d[l] = shifted[l][DIV_W-1:0];
      end
      dvd_d[l] = {dvd_q[l][OP_W-2:0], 1'b0};
    end
  end

  // Step counter.
  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(OP_W);
    end else if (stepping) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Operand, divisor and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      dvd_q <= op_i;
      rem_q <= '0;
    end else if (stepping) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

endmodule

@@ sv/ipdt_back.sv @@
// ----------------------------------------------------------------------------
// ipdt_back: execution side of the delay tracker
// Pops classified words, reduces them with the modulo unit, checks the phase
// against the prediction, forms both delays and holds the result word in the
// output register. It also keeps the tracking state.
// ----------------------------------------------------------------------------
module ipdt_back #(
  parameter int SAMPLE_COUNT_WIDTH = ipdt_pkg::SAMPLE_COUNT_WIDTH_DEF,
  parameter int FRAME_COUNT_WIDTH  = ipdt_pkg::FRAME_COUNT_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  ipdt_pkg::ipdt_qstat_t                           qstat_i,
  input  logic [3*SAMPLE_COUNT_WIDTH+FRAME_COUNT_WIDTH:0] item_i,
  output logic                                            pop_o,
  input  logic [ipdt_pkg::LATENCY_WIDTH-1:0]              output_latency_i,
  input  logic [ipdt_pkg::LATENCY_WIDTH-1:0]              input_latency_i,
  output logic                                            out_valid_o,
  input  logic                                            out_stall_i,
  output logic                                            valid_res_o,
  output logic                                            generation_reset_o,
  output logic                                            anomaly_o,
  output logic [SAMPLE_COUNT_WIDTH:0]                     dac_delay_o,
  output logic [SAMPLE_COUNT_WIDTH:0]                     adc_delay_o
);
  import ipdt_pkg::*;

  localparam int SW   = SAMPLE_COUNT_WIDTH;
  localparam int FW   = FRAME_COUNT_WIDTH;
  localparam int OP_W = (SW > FW) ? SW : FW;

  // Field positions inside a queue word.
  localparam int CUR_LSB = FW;
  localparam int PH_LSB  = FW + SW;
  localparam int LEN_LSB = FW + 2 * SW;
  localparam int NT_BIT  = FW + 3 * SW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FIX  = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          primed_q, primed_d;
  logic [SW-1:0] last_len_q, last_len_d;
  logic [SW-1:0] pred_q, pred_d;
  logic          out_valid_q, out_valid_d;

  logic [SW-1:0] len_q;
  logic [FW-1:0] fr_q;
  logic          rst_need_q;
  logic [SW-1:0] d1_q, fwd_q, pnext_q, dac_m_q, adc_m_q;
  logic          anom_q;
  logic          out_vres_q, out_gen_q, out_anom_q;
  logic [SW:0]   out_dac_q, out_adc_q;

  logic [SW-1:0] it_len, it_ph, it_cur;
  logic [FW-1:0] it_fr;
  logic          it_nt;

  logic                            mod_start;
  logic [NUM_LANES-1:0][OP_W-1:0]  mod_ops;
  logic [NUM_LANES-1:0][SW-1:0]    mod_rem;
  ipdt_modstat_t                   mod_stat;

  logic          slot_free, take_idle, load_out_nt, load_out_full, latch_item;
  logic [SW-1:0] r_cur, r_ph, r_ol, r_il, r_fr;
  logic [SW-1:0] d1_d, fwd_d, pnext_d, dac_m_d, adc_m_d, back_dist, circ;
  logic [SW:0]   pn_sum, dac_sum;
  logic [OP_W-1:0] fr_w, len_w, tol;
  logic          anom_d;
  logic [OP_W:0] dac_full, adc_full;

  // Unpack the queue word.
  assign it_fr  = item_i[FW-1:0];
  assign it_cur = item_i[CUR_LSB +: SW];
  assign it_ph  = item_i[PH_LSB +: SW];
  assign it_len = item_i[LEN_LSB +: SW];
  assign it_nt  = item_i[NT_BIT];

  // The output register takes a new word when empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;

  // Word leaves the queue: at once for timing words, with the result for
  // no-timing words.
  assign take_idle     = (state_q == ST_IDLE) && !qstat_i.empty;
  assign load_out_nt   = take_idle && it_nt && slot_free;
  assign latch_item    = take_idle && !it_nt;
  assign load_out_full = (state_q == ST_OUT) && slot_free;
  assign pop_o         = load_out_nt || latch_item;

  // Modulo unit operands, all reduced by the interval length.
  assign mod_start            = latch_item;
  assign mod_ops[LN_CURSOR]   = OP_W'(it_cur);
  assign mod_ops[LN_PHASE]    = OP_W'(it_ph);
  assign mod_ops[LN_OUTLAT]   = OP_W'(output_latency_i);
  assign mod_ops[LN_INLAT]    = OP_W'(input_latency_i);
  assign mod_ops[LN_FRAMES]   = OP_W'(it_fr);

  ipdt_mod_unit #(
    .DIV_W (SW),
    .OP_W  (OP_W)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .div_i  (it_len),
    .op_i   (mod_ops),
    .rem_o  (mod_rem),
    .stat_o (mod_stat)
  );

  assign r_cur = mod_rem[LN_CURSOR];
  assign r_ph  = mod_rem[LN_PHASE];
  assign r_ol  = mod_rem[LN_OUTLAT];
  assign r_il  = mod_rem[LN_INLAT];
  assign r_fr  = mod_rem[LN_FRAMES];

  // First fix-up step: cursor minus phase, next prediction and forward
  // distance from the old prediction, each brought back into [0, L).
  assign d1_d    = (r_cur >= r_ph) ? r_cur - r_ph : r_cur + len_q - r_ph;
  assign pn_sum  = {1'b0, r_ph} + {1'b0, r_fr};
  assign pnext_d = (pn_sum >= {1'b0, len_q}) ? SW'(pn_sum - {1'b0, len_q})
                                             : pn_sum[SW-1:0];
  assign fwd_d   = (r_ph >= pred_q) ? r_ph - pred_q : r_ph + len_q - pred_q;

  // Second step: add or take off the latencies, and compare the circular
  // distance with the tolerance.
  assign dac_sum   = {1'b0, d1_q} + {1'b0, r_ol};
  assign dac_m_d   = (dac_sum >= {1'b0, len_q}) ? SW'(dac_sum - {1'b0, len_q})
                                                : dac_sum[SW-1:0];
  assign adc_m_d   = (d1_q >= r_il) ? d1_q - r_il : d1_q + len_q - r_il;
  assign back_dist = len_q - fwd_q;
  assign circ      = (fwd_q < back_dist) ? fwd_q : back_dist;
  assign fr_w      = OP_W'(fr_q);
  assign len_w     = OP_W'(len_q);
  assign tol       = (fr_w < len_w) ? fr_w : len_w;
  assign anom_d    = !rst_need_q && (OP_W'(circ) > tol);

  // Final step: add the frame count to both delays.
  assign dac_full = {1'b0, OP_W'(dac_m_q)} + {1'b0, fr_w};
  assign adc_full = {1'b0, OP_W'(adc_m_q)} + {1'b0, fr_w};

  // Sequencer and tracking state.
  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    last_len_d  = last_len_q;
    pred_d      = pred_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (load_out_nt) begin
          out_valid_d = 1'b1;
          primed_d    = 1'b0;
        end else if (latch_item) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_stat.last_step) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        state_d = ST_MIX;
      end
      ST_MIX: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out_full) begin
          out_valid_d = 1'b1;
          primed_d    = 1'b1;
          last_len_d  = len_q;
          pred_d      = pnext_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      last_len_q  <= '0;
      pred_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      last_len_q  <= last_len_d;
      pred_q      <= pred_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    if (latch_item) begin
      len_q      <= it_len;
      fr_q       <= it_fr;
      rst_need_q <= !primed_q || (last_len_q != it_len);
    end
    if (state_q == ST_FIX) begin
      d1_q    <= d1_d;
      fwd_q   <= fwd_d;
      pnext_q <= pnext_d;
    end
    if (state_q == ST_MIX) begin
      dac_m_q <= dac_m_d;
      adc_m_q <= adc_m_d;
      anom_q  <= anom_d;
    end
    if (load_out_nt) begin
      out_vres_q <= 1'b0;
      out_gen_q  <= primed_q;
      out_anom_q <= 1'b0;
      out_dac_q  <= '0;
      out_adc_q  <= '0;
    end else if (load_out_full) begin
      out_vres_q <= 1'b1;
      out_gen_q  <= rst_need_q || anom_q;
      out_anom_q <= anom_q;
      out_dac_q  <= dac_full[SW:0];
      out_adc_q  <= adc_full[SW:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign valid_res_o        = out_vres_q;
  assign generation_reset_o = out_gen_q;
  assign anomaly_o          = out_anom_q;
  assign dac_delay_o        = out_dac_q;
  assign adc_delay_o        = out_adc_q;

endmodule

@@ sv/interval_phase_delay_tracker_top.sv @@
// ----------------------------------------------------------------------------
// interval_phase_delay_tracker_top: remote interval phase and delay tracker
// Once per audio block, tracks the remote interval phase, flags generation
// resets and anomalies, and derives the playback and capture delays.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake               | Word
//   ---------+-----------+-------------------------+-------------------------
//   in       | input     | in_valid_i / in_stall_o | length, phase, cursor,
//            |           |                         | frames
//   out      | output    | out_valid_o/out_stall_i | valid_res, reset flag,
//            |           |                         | anomaly, dac, adc delays
//   cfg      | input     | cfg_valid_i/cfg_ready_o | register index, data
//
// A word with timing goes through the bit-serial modulo unit of the back,
// which reduces all five operands in parallel lanes; a word without timing
// goes straight to the output register. A two-word queue lets the input
// keep accepting while the back works or while a finished word waits under
// out_stall_i. Reset clears the tracking state and both latency registers
// to zero.
//
module interval_phase_delay_tracker_top #(
  parameter int SAMPLE_COUNT_WIDTH = ipdt_pkg::SAMPLE_COUNT_WIDTH_DEF,
  parameter int FRAME_COUNT_WIDTH  = ipdt_pkg::FRAME_COUNT_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [SAMPLE_COUNT_WIDTH-1:0]          interval_length_i,
  input  logic [SAMPLE_COUNT_WIDTH-1:0]          interval_phase_i,
  input  logic [SAMPLE_COUNT_WIDTH-1:0]          write_cursor_i,
  input  logic [FRAME_COUNT_WIDTH-1:0]           block_frames_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   valid_res_o,
  output logic                                   generation_reset_o,
  output logic                                   anomaly_o,
  output logic [SAMPLE_COUNT_WIDTH:0]            dac_delay_o,
  output logic [SAMPLE_COUNT_WIDTH:0]            adc_delay_o,
  // Configuration channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ipdt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [ipdt_pkg::LATENCY_WIDTH-1:0]     cfg_data_i
);
  import ipdt_pkg::*;

  localparam int ITEM_W = 3 * SAMPLE_COUNT_WIDTH + FRAME_COUNT_WIDTH + 1;

  logic [LATENCY_WIDTH-1:0] out_lat_q, out_lat_d;
  logic [LATENCY_WIDTH-1:0] in_lat_q, in_lat_d;
  logic                     q_push, q_pop;
  logic [ITEM_W-1:0]        q_in, q_out;
  ipdt_qstat_t              q_stat;

  // Latency registers; writes to other indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    out_lat_d = out_lat_q;
    in_lat_d  = in_lat_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OUTPUT_LATENCY: out_lat_d = cfg_data_i;
        CFG_INPUT_LATENCY:  in_lat_d  = cfg_data_i;
        default: begin
          out_lat_d = out_lat_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_lat_q <= '0;
      in_lat_q  <= '0;
    end else begin
      out_lat_q <= out_lat_d;
      in_lat_q  <= in_lat_d;
    end
  end

  // Front: accept and classify words.
  ipdt_front #(
    .SAMPLE_COUNT_WIDTH(SAMPLE_COUNT_WIDTH),
    .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .interval_length_i(interval_length_i),
    .interval_phase_i (interval_phase_i),
    .write_cursor_i   (write_cursor_i),
    .block_frames_i   (block_frames_i),
    .qstat_i          (q_stat),
    .push_o           (q_push),
    .item_o           (q_in)
  );

  // Queue between front and back.
  ipdt_queue #(
    .DATA_W(ITEM_W)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_in),
    .pop_i (q_pop),
    .data_o(q_out),
    .stat_o(q_stat)
  );

  // Back: reduce, check and form the result word.
  ipdt_back #(
    .SAMPLE_COUNT_WIDTH(SAMPLE_COUNT_WIDTH),
    .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .qstat_i           (q_stat),
    .item_i            (q_out),
    .pop_o             (q_pop),
    .output_latency_i  (out_lat_q),
    .input_latency_i   (in_lat_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .valid_res_o       (valid_res_o),
    .generation_reset_o(generation_reset_o),
    .anomaly_o         (anomaly_o),
    .dac_delay_o       (dac_delay_o),
    .adc_delay_o       (adc_delay_o)
  );

  // The front never pushes into a full queue, and the back never pops an
  // empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push |-> !q_stat.full) and (q_pop |-> !q_stat.empty))
    else $error("queue overflow or underflow");

  // A word without timing carries zero delays and no anomaly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (dac_delay_o == '0) && (adc_delay_o == '0) && !anomaly_o)
    else $error("invalid result word carries delays or anomaly");

  // An anomaly always comes with a generation reset on a timed word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && anomaly_o) |-> (generation_reset_o && valid_res_o))
    else $error("anomaly without generation reset");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interval phase delay tracker
// A directed table covers the extremes, the no-timing and length-change
// cases, and the phase tolerance edges. Random traffic then follows, mostly
// phase-coherent streams on one interval length. Every result word is checked
// against the bench's tracker model or a typed row. Random idling on both
// sides, one long receiver hold-off and several latency settings are used.
// ----------------------------------------------------------------------------
module tb_top;
  import ipdt_pkg::*;

  localparam int SW = SAMPLE_COUNT_WIDTH_DEF;
  localparam int FW = FRAME_COUNT_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int NUM_PHASES = 6;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRESSURE_WORDS = 12;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NO_REGISTER = 2'd3;
  localparam logic [SW-1:0] SMAX = '1;
  localparam logic [FW-1:0] FMAX = '1;

  typedef struct packed {
    logic [SW-1:0] len;
    logic [SW-1:0] phase;
    logic [SW-1:0] cursor;
    logic [FW-1:0] frames;
  } block_word_t;

  typedef struct packed {
    logic          valid_res;
    logic          generation_reset;
    logic          anomaly;
    logic [SW:0]   dac_delay;
    logic [SW:0]   adc_delay;
  } delay_result_t;

  typedef struct {
    block_word_t   word;
    bit            typed;
    delay_result_t result;
  } stim_row_t;

  localparam delay_result_t FROM_TRACKER = '0;

  // Directed rows; a typed result is used only where it is obvious.
  stim_row_t directed_rows [22] = '{
    // No timing right after reset: nothing primed, nothing to report.
    '{'{24'd0, SMAX, SMAX, FMAX}, 1'b1, '{1'b0, 1'b0, 1'b0, 25'd0, 25'd0}},
    // Unit length with all fields at maximum: everything reduces to zero.
    '{'{24'd1, SMAX, SMAX, FMAX}, 1'b1, '{1'b1, 1'b1, 1'b0, 25'd65535, 25'd65535}},
    '{'{24'd1, 24'd0, 24'd0, 16'd0}, 1'b1, '{1'b1, 1'b0, 1'b0, 25'd0, 25'd0}},
    // Timing lost while primed, then lost again while unprimed.
    '{'{24'd0, 24'd0, 24'd0, 16'd0}, 1'b1, '{1'b0, 1'b1, 1'b0, 25'd0, 25'd0}},
    '{'{24'd0, 24'd5, 24'd6, 16'd7}, 1'b1, '{1'b0, 1'b0, 1'b0, 25'd0, 25'd0}},
    // Maximum length.
    '{'{SMAX, SMAX, SMAX, FMAX}, 1'b1, '{1'b1, 1'b1, 1'b0, 25'd65535, 25'd65535}},
    '{'{SMAX, 24'd65535, 24'd0, 16'd0}, 1'b0, FROM_TRACKER},
    // Length change, on-time phase, then one sample past the tolerance.
    '{'{24'd1000, 24'd100, 24'd500, 16'd10}, 1'b0, FROM_TRACKER},
    '{'{24'd1000, 24'd110, 24'd7, 16'd10}, 1'b0, FROM_TRACKER},
    '{'{24'd1000, 24'd131, 24'd999, 16'd10}, 1'b0, FROM_TRACKER},
    // Exactly at the tolerance behind the prediction.
    '{'{24'd1000, 24'd131, 24'd0, 16'd10}, 1'b0, FROM_TRACKER},
    '{'{24'd1000, 24'd995, 24'd250, 16'd50}, 1'b0, FROM_TRACKER},
    // Distance measured across the wrap point.
    '{'{24'd1000, 24'd5, 24'd3, 16'd40}, 1'b0, FROM_TRACKER},
    // Half an interval away, just over and just at the tolerance.
    '{'{24'd1000, 24'd545, 24'd0, 16'd499}, 1'b0, FROM_TRACKER},
    '{'{24'd1000, 24'd2544, 24'd1234, 16'd500}, 1'b0, FROM_TRACKER},
    // More frames than the interval holds.
    '{'{24'd1000, 24'd999, 24'd12345, 16'd60000}, 1'b0, FROM_TRACKER},
    '{'{24'd1001, 24'd0, 24'd0, 16'd0}, 1'b0, FROM_TRACKER},
    '{'{24'd0, 24'd1, 24'd2, 16'd3}, 1'b1, '{1'b0, 1'b1, 1'b0, 25'd0, 25'd0}},
    // Same length as before the gap, but no longer primed.
    '{'{24'd1001, 24'd500, 24'd100, 16'd1}, 1'b0, FROM_TRACKER},
    '{'{24'd1001, 24'd501, 24'd100, 16'd1}, 1'b0, FROM_TRACKER},
    '{'{24'hFFFFFE, 24'h7FFFFF, 24'd0, 16'd0}, 1'b0, FROM_TRACKER},
    '{'{24'hFFFFFE, 24'd0, SMAX, FMAX}, 1'b0, FROM_TRACKER}
  };

  // Clock, reset and block ports.
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [SW-1:0]     interval_length_i;
  logic [SW-1:0]     interval_phase_i;
  logic [SW-1:0]     write_cursor_i;
  logic [FW-1:0]     block_frames_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              valid_res_o;
  logic              generation_reset_o;
  logic              anomaly_o;
  logic [SW:0]       dac_delay_o;
  logic [SW:0]       adc_delay_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i;
  logic [LATENCY_WIDTH-1:0]   cfg_data_i;

  // Tracker model state and latency copies.
  longint unsigned out_latency;
  longint unsigned in_latency;
  longint unsigned last_length;
  longint unsigned predicted_phase;
  bit              primed;

  delay_result_t pending_delays[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            tx_burst;
  bit            tx_pressure;
  bit            rx_burst;
  int unsigned   hold_off_cycles;

  interval_phase_delay_tracker_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .interval_length_i  (interval_length_i),
    .interval_phase_i   (interval_phase_i),
    .write_cursor_i     (write_cursor_i),
    .block_frames_i     (block_frames_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .valid_res_o        (valid_res_o),
    .generation_reset_o (generation_reset_o),
    .anomaly_o          (anomaly_o),
    .dac_delay_o        (dac_delay_o),
    .adc_delay_o        (adc_delay_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Tracks the phase for one accepted word and returns its result word.
  function automatic delay_result_t track_block(block_word_t w);
    longint unsigned len, frames, cur_m, ph_m, fwd, circ, tol, dac, adc;
    delay_result_t   r;
    r = '0;
    len = w.len;
    frames = w.frames;
    if (len == 0) begin
      r.generation_reset = primed;
      primed = 1'b0;
      return r;
    end
    cur_m = w.cursor % len;
    ph_m = w.phase % len;
    r.valid_res = 1'b1;
    if (!primed || last_length != len) begin
      r.generation_reset = 1'b1;
    end else begin
      fwd = (ph_m + len - predicted_phase % len) % len;
      circ = (fwd < len - fwd) ? fwd : len - fwd;
      tol = (frames < len) ? frames : len;
      if (circ > tol) begin
        r.generation_reset = 1'b1;
        r.anomaly = 1'b1;
      end
    end
    dac = (cur_m + out_latency % len + len - ph_m) % len;
    adc = (cur_m + len - in_latency % len + len - ph_m) % len;
    r.dac_delay = (SW+1)'(dac + frames);
    r.adc_delay = (SW+1)'(adc + frames);
    primed = 1'b1;
    last_length = len;
    predicted_phase = (ph_m + frames) % len;
    return r;
  endfunction

  // Draws one word; most words continue the current stream near its phase.
  function automatic block_word_t random_block_word();
    block_word_t     w;
    int unsigned     pick, fpick, lpick, mpick;
    longint unsigned len, tol, half, mag, fwd, base, room, lo;
    pick = $urandom_range(0, 99);
    fpick = $urandom_range(0, 99);
    w.cursor = SW'($urandom);
    w.phase = SW'($urandom);
    if (fpick < 60) begin
      w.frames = FW'($urandom_range(0, 64));
    end else if (fpick < 85) begin
      w.frames = FW'($urandom_range(0, 4095));
    end else begin
      w.frames = FW'($urandom);
    end
    if (pick < 5) begin
      w.len = '0;
    end else if (pick < 12 || last_length == 0) begin
      lpick = $urandom_range(0, 99);
      if (lpick < 40) begin
        w.len = SW'($urandom_range(1, 64));
      end else if (lpick < 80) begin
        w.len = SW'($urandom_range(65, 100000));
      end else begin
        w.len = SW'($urandom);
      end
    end else if (pick < 19) begin
      w.len = SW'($urandom);
    end else begin
      w.len = SW'(last_length);
      if (pick >= 24) begin
        // Place the phase a chosen circular distance from the prediction.
        len = last_length;
        tol = (w.frames < len) ? w.frames : len;
        half = len / 2;
        mpick = $urandom_range(0, 99);
        if (mpick < 70) begin
          mag = $urandom_range(0, int'((tol < half) ? tol : half));
        end else if (mpick < 85) begin
          mag = (tol < half) ? tol + $urandom_range(0, 1) : half;
        end else begin
          lo = (tol + 1 < half) ? tol + 1 : half;
          mag = $urandom_range(int'(lo), int'(half));
        end
        fwd = ($urandom_range(0, 1) != 0) ? (len - mag) % len : mag;
        base = (predicted_phase + fwd) % len;
        room = (longint'(SMAX) - base) / len;
        if ($urandom_range(0, 3) == 0) begin
          base = base + len * $urandom_range(0, int'(room));
        end
        w.phase = SW'(base);
      end
    end
    return w;
  endfunction

  // Offers one word after a random gap and records its expected result.
  task automatic offer_word(block_word_t w, bit typed, delay_result_t typed_result);
    int unsigned   gap;
    delay_result_t predicted;
    gap = (tx_burst || tx_pressure) ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 99) == 0) begin
      tx_burst = !tx_burst;
    end
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    interval_length_i = w.len;
    interval_phase_i = w.phase;
    write_cursor_i = w.cursor;
    block_frames_i = w.frames;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = track_block(w);
    pending_delays.push_back(typed ? typed_result : predicted);
    @(negedge clk_i);
  endtask

  // Writes a latency register once the block has drained.
  task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                logic [LATENCY_WIDTH-1:0] data);
    in_valid_i = 1'b0;
    while (pending_delays.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_index_i = index;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_OUTPUT_LATENCY: out_latency = data;
      CFG_INPUT_LATENCY:  in_latency = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: each accepted word is matched against the oldest one due.
  always @(posedge clk_i) begin : result_check
    delay_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_delays.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        want = pending_delays.pop_front();
        check_field("valid_res", want.valid_res, valid_res_o);
        check_field("generation_reset", want.generation_reset, generation_reset_o);
        check_field("anomaly", want.anomaly, anomaly_o);
        check_field("dac_delay", want.dac_delay, dac_delay_o);
        check_field("adc_delay", want.adc_delay, adc_delay_o);
      end
    end
  end

  // Receiver: a random stall before each word, or a long hold when requested.
  initial begin : receiver
    int unsigned wait_cycles;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        wait_cycles = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        wait_cycles = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if ($urandom_range(0, 99) == 0) begin
        rx_burst = !rx_burst;
      end
      if (wait_cycles > 0) begin
        out_stall_i = 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** interval_phase_delay_tracker_top: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases per setting.
  initial begin : stimulus
    logic [LATENCY_WIDTH-1:0] out_setting, in_setting;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    interval_length_i = '0;
    interval_phase_i = '0;
    write_cursor_i = '0;
    block_frames_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_OUTPUT_LATENCY;
    cfg_data_i = '0;
    out_latency = 0;
    in_latency = 0;
    last_length = 0;
    predicted_phase = 0;
    primed = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    tx_burst = 1'b0;
    tx_pressure = 1'b0;
    rx_burst = 1'b0;
    hold_off_cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin out_setting = '1; in_setting = '1; end
        1: begin out_setting = '0; in_setting = '1; end
        2: begin out_setting = '1; in_setting = '0; end
        4: begin out_setting = 16'd1; in_setting = 16'd1; end
        default: begin
          out_setting = LATENCY_WIDTH'($urandom);
          in_setting = LATENCY_WIDTH'($urandom);
        end
      endcase
      write_register(CFG_OUTPUT_LATENCY, out_setting);
      write_register(CFG_INPUT_LATENCY, in_setting);
      // A write to an unused index must leave both latencies alone.
      if (ph == 0) begin
        write_register(CFG_NO_REGISTER, 16'h5A5A);
      end
      // Drain fully, then hold the receiver off while words keep coming.
      if (ph == 3) begin
        in_valid_i = 1'b0;
        while (pending_delays.size() != 0) @(negedge clk_i);
        hold_off_cycles = LONG_HOLD_CYCLES;
        tx_pressure = 1'b1;
        repeat (PRESSURE_WORDS) offer_word(random_block_word(), 1'b0, FROM_TRACKER);
        tx_pressure = 1'b0;
      end
      repeat (RANDOM_PER_PHASE) offer_word(random_block_word(), 1'b0, FROM_TRACKER);
    end

    in_valid_i = 1'b0;
    while (pending_delays.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("** interval_phase_delay_tracker_top: PASSED **");
    end else begin
      $display("** interval_phase_delay_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule
